[rtl/elimination_tree_builder_macros.svh]
// Assertion macros for the elimination tree builder RTL.
`ifndef ELIMINATION_TREE_BUILDER_MACROS_SVH
`define ELIMINATION_TREE_BUILDER_MACROS_SVH

`ifndef ASSERT_OFF
// Checked on every clock edge outside reset.
`define ETB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// Checked on every clock edge, reset included.
`define ETB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);
`else
`define ETB_ASSERT(lbl, prop, msg)
`define ETB_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[rtl/etb_pkg.sv]
// Shared types and constants of the elimination tree builder.
package etb_pkg;

    // Width of the row, column, child and parent fields.
    localparam int FIELD_W = 10;

    // Width of the matrix epoch tag stored beside each ancestor link.
    localparam int EPOCH_W = 8;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = {EPOCH_W{1'b1}};

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;

    // One classified entry as it waits in the queue.
    typedef struct packed {
        logic [FIELD_W-1:0] row;
        logic [FIELD_W-1:0] col;
        logic               new_matrix;
        logic               skip;
    } t_entry;

    // One word of the ancestor store: matrix epoch and ancestor link.
    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic [FIELD_W-1:0] link;
    } t_link_word;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef struct packed {
        logic clearing;
    } t_back_status;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_WALK
    } t_back_state;

endpackage

[rtl/etb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module etb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // The read returns the word held before a write in the same cycle.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/etb_front.sv]
// Input side: accepts entries, classifies them and feeds the queue.
module etb_front #(
    parameter int MAX_NODES = 1024
) (
    input  logic                        i_valid,
    input  logic [etb_pkg::FIELD_W-1:0] i_row,
    input  logic [etb_pkg::FIELD_W-1:0] i_column,
    input  logic                        i_new_matrix,
    output logic                        o_stall,
    input  etb_pkg::t_queue_status      i_q_status,
    input  etb_pkg::t_back_status       i_back_status,
    output logic                        o_push,
    output etb_pkg::t_entry             o_entry
);

    import etb_pkg::*;

    logic accept;
    logic row_out;
    logic col_out;
    logic skip;

    // No transfer while the queue is full or the store is being cleared.
    assign o_stall = i_q_status.full | i_back_status.clearing;
    assign accept  = i_valid & ~o_stall;

    // Entries outside the node range, on the diagonal or above it cause no walk.
    assign row_out = {{(32-FIELD_W){1'b0}}, i_row} >= 32'(MAX_NODES);
    assign col_out = {{(32-FIELD_W){1'b0}}, i_column} >= 32'(MAX_NODES);
    assign skip    = row_out | col_out | (i_column >= i_row);

    // A skipped entry only matters when it starts a new matrix.
    assign o_push = accept & (i_new_matrix | ~skip);

    always_comb begin
        o_entry.row        = i_row;
        o_entry.col        = i_column;
        o_entry.new_matrix = i_new_matrix;
        o_entry.skip       = skip;
    end

endmodule

[rtl/etb_queue.sv]
// Short queue of classified entries between the front and the back.
module etb_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  etb_pkg::t_entry        i_entry,
    input  logic                   i_pop,
    output etb_pkg::t_entry        o_head,
    output etb_pkg::t_queue_status o_status
);

    import etb_pkg::*;

    t_entry              r_slot [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;
    logic [QUEUE_AW:0]   n_count;
    logic                do_push;
    logic                do_pop;

    assign do_push = i_push & ~o_status.full;
    assign do_pop  = i_pop & ~o_status.empty;

    always_comb begin
        o_status.full  = r_count == (QUEUE_AW+1)'(QUEUE_DEPTH);
        o_status.empty = r_count == '0;
        o_head         = r_slot[r_rd_ptr];
    end

    always_comb begin
        n_count = r_count;
        if (do_push & ~do_pop) begin
            n_count = r_count + (QUEUE_AW+1)'(1);
        end else if (do_pop & ~do_push) begin
            n_count = r_count - (QUEUE_AW+1)'(1);
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

endmodule

[rtl/etb_back.sv]
// Walker: follows and compresses ancestor paths and emits parent links.
`include "elimination_tree_builder_macros.svh"

module etb_back #(
    parameter int MAX_NODES = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  etb_pkg::t_entry             i_head,
    input  etb_pkg::t_queue_status      i_q_status,
    output logic                        o_pop,
    output etb_pkg::t_back_status       o_status,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [etb_pkg::FIELD_W-1:0] o_child,
    output logic [etb_pkg::FIELD_W-1:0] o_parent
);

    import etb_pkg::*;

    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int WORD_W = $bits(t_link_word);

    t_back_state        r_state;
    t_back_state        n_state;
    logic [EPOCH_W-1:0] r_epoch;
    logic [EPOCH_W-1:0] n_epoch;
    logic [NODE_W-1:0]  r_clr_idx;
    logic [NODE_W-1:0]  n_clr_idx;
    logic [FIELD_W-1:0] r_row;
    logic [FIELD_W-1:0] n_row;
    logic [NODE_W-1:0]  r_node;
    logic [NODE_W-1:0]  n_node;
    logic               r_skip;
    logic               n_skip;
    logic               r_pend;
    logic               n_pend;
    logic               r_fwd_hit;
    t_link_word         r_fwd_data;
    logic               r_out_valid;
    logic [FIELD_W-1:0] r_child;
    logic [FIELD_W-1:0] r_parent;

    logic               rd_en;
    logic [NODE_W-1:0]  rd_addr;
    logic [WORD_W-1:0]  rd_raw;
    logic               wr_en;
    logic [NODE_W-1:0]  wr_addr;
    t_link_word         wr_data;
    t_link_word         cur;
    logic               link_valid;
    logic               link_is_row;
    logic               clr_last;
    logic               wrap;
    logic               out_free;
    logic               out_load;

    // Ancestor store: link and the epoch of the matrix that wrote it.
    etb_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_NODES)
    ) u_link_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_raw)
    );

    // Current word of the walk, with a write to the same node forwarded.
    always_comb begin
        cur         = r_fwd_hit ? r_fwd_data : t_link_word'(rd_raw);
        link_valid  = cur.epoch == r_epoch;
        link_is_row = cur.link == r_row;
        clr_last    = r_clr_idx == NODE_W'(MAX_NODES - 1);
        wrap        = i_head.new_matrix & (r_epoch == EPOCH_LAST);
        out_free    = ~r_out_valid | ~i_stall;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (clr_last) begin
                    n_state = (r_pend & ~r_skip) ? S_START : S_IDLE;
                end
            end
            S_IDLE: begin
                if (!i_q_status.empty) begin
                    if (wrap) begin
                        n_state = S_CLEAR;
                    end else if (!i_head.skip) begin
                        n_state = S_WALK;
                    end
                end
            end
            S_START: begin
                n_state = S_WALK;
            end
            S_WALK: begin
                if (link_valid) begin
                    n_state = link_is_row ? S_IDLE : S_WALK;
                end else if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Store accesses, queue pop and working registers.
    always_comb begin
        rd_en     = 1'b0;
        rd_addr   = r_node;
        wr_en     = 1'b0;
        wr_addr   = r_node;
        wr_data   = '{epoch: r_epoch, link: r_row};
        o_pop     = 1'b0;
        out_load  = 1'b0;
        n_epoch   = r_epoch;
        n_clr_idx = r_clr_idx;
        n_row     = r_row;
        n_node    = r_node;
        n_skip    = r_skip;
        n_pend    = r_pend;
        case (r_state)
            S_CLEAR: begin
                wr_en     = 1'b1;
                wr_addr   = r_clr_idx;
                wr_data   = '0;
                n_clr_idx = r_clr_idx + NODE_W'(1);
                if (clr_last) begin
                    n_pend = 1'b0;
                end
            end
            S_IDLE: begin
                if (!i_q_status.empty) begin
                    o_pop  = 1'b1;
                    n_row  = i_head.row;
                    n_node = NODE_W'(i_head.col);
                    n_skip = i_head.skip;
                    if (wrap) begin
                        // Epoch tags run out: clear the store and restart them.
                        n_epoch   = EPOCH_FIRST;
                        n_pend    = 1'b1;
                        n_clr_idx = '0;
                    end else begin
                        if (i_head.new_matrix) begin
                            n_epoch = r_epoch + EPOCH_W'(1);
                        end
                        rd_en   = ~i_head.skip;
                        rd_addr = NODE_W'(i_head.col);
                    end
                end
            end
            S_START: begin
                rd_en = 1'b1;
            end
            S_WALK: begin
                if (link_valid && !link_is_row) begin
                    // Repoint this node at the row and step to its ancestor.
                    wr_en   = 1'b1;
                    rd_en   = 1'b1;
                    rd_addr = NODE_W'(cur.link);
                    n_node  = NODE_W'(cur.link);
                end else if (!link_valid && out_free) begin
                    // Root of the path reached: the row becomes its parent.
                    wr_en    = 1'b1;
                    out_load = 1'b1;
                end
            end
            default: begin
                n_pend = 1'b0;
            end
        endcase
    end

    assign o_status.clearing = r_state == S_CLEAR;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_epoch     <= EPOCH_FIRST;
            r_clr_idx   <= '0;
            r_pend      <= 1'b0;
            r_fwd_hit   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_epoch   <= n_epoch;
            r_clr_idx <= n_clr_idx;
            r_pend    <= n_pend;
            if (rd_en) begin
                r_fwd_hit <= wr_en & (wr_addr == rd_addr);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_row  <= n_row;
        r_node <= n_node;
        r_skip <= n_skip;
        if (rd_en) begin
            r_fwd_data <= wr_data;
        end
        if (out_load) begin
            r_child  <= FIELD_W'(r_node);
            r_parent <= r_row;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_child  = r_child;
    assign o_parent = r_parent;

    `ETB_ASSERT(a_epoch_nonzero, r_epoch != '0, "epoch tag zero would mark every link valid")
    `ETB_ASSERT(a_no_result_in_clear, (r_state == S_CLEAR) |-> !out_load, "result during clear")
    `ETB_ASSERT(a_idle_after_result, out_load |=> (r_state == S_IDLE), "walk kept going after result")
    `ETB_ASSERT(a_no_pop_while_busy, o_pop |-> (r_state == S_IDLE), "queue popped mid-walk")

endmodule

[rtl/elimination_tree_builder.sv]
// In the walker an entry follows the links of its ancestor path one by one; a result
// is loaded into the output register when the walk reaches the root. Entries on or
// above the diagonal, or out of range, give no result.
// Throughput is set by the single read port of the ancestor store: one link a cycle.
// After reset, and on every 255th new matrix, a clearing pass writes every word of the
// store with input transfers stalled.
module elimination_tree_builder #(
    parameter int MAX_NODES = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [etb_pkg::FIELD_W-1:0] i_row,
    input  logic [etb_pkg::FIELD_W-1:0] i_column,
    input  logic                        i_new_matrix,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [etb_pkg::FIELD_W-1:0] o_child,
    output logic [etb_pkg::FIELD_W-1:0] o_parent
);

    import etb_pkg::*;

    t_entry        push_entry;
    t_entry        head;
    logic          push;
    logic          pop;
    t_queue_status q_status;
    t_back_status  back_status;

    // Front: accepts and classifies each transfer.
    etb_front #(
        .MAX_NODES (MAX_NODES)
    ) u_front (
        .i_valid       (i_valid),
        .i_row         (i_row),
        .i_column      (i_column),
        .i_new_matrix  (i_new_matrix),
        .o_stall       (o_stall),
        .i_q_status    (q_status),
        .i_back_status (back_status),
        .o_push        (push),
        .o_entry       (push_entry)
    );

    // Queue decoupling the front from the walker.
    etb_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    // Back: path walk with compression and result register.
    etb_back #(
        .MAX_NODES (MAX_NODES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_status   (back_status),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_child    (o_child),
        .o_parent   (o_parent)
    );

endmodule
